// ----- src/skt_pkg.sv -----
package skt_pkg;

  typedef enum logic [2:0] {
    KIND_INSERT   = 3'd0,
    KIND_LOOKUP   = 3'd1,
    KIND_SET_LINE = 3'd2,
    KIND_REMOVE   = 3'd3,
    KIND_RANK     = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    STAT_OK        = 4'd0,
    STAT_BAD_SEATS = 4'd1,
    STAT_BAD_KEY   = 4'd2,
    STAT_DUPLICATE = 4'd3,
    STAT_NOT_FOUND = 4'd4,
    STAT_HAS_LINE  = 4'd5,
    STAT_BAD_LINE  = 4'd6,
    STAT_FULL      = 4'd7,
    STAT_BAD_RANK  = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CMP  = 2'd1,
    S_UPD  = 2'd2
  } state_e;

  typedef enum logic [1:0] {
    REG_KEY_LIMIT  = 2'd0,
    REG_SEAT_LIMIT = 2'd1,
    REG_LINE_LIMIT = 2'd2
  } cfg_reg_e;

  localparam logic [7:0] MIN_SEATS = 8'd9;

  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  seats;
    logic [7:0]  line;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic        cmp_en;
    logic        rank_mode;
    logic        insert_go;
    logic        remove_go;
    logic        setline_go;
    logic [15:0] op_key;
    entry_t      new_entry;
  } ctl_t;

endpackage

// ----- src/skt_cell.sv -----
module skt_cell import skt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  ctl_t   ctl_i,
  input  logic   occ_i,
  input  logic   rank_hit_i,
  input  entry_t left_i,
  input  logic   left_lt_i,
  input  entry_t right_i,
  output entry_t entry_o,
  output logic   lt_o,
  output logic   sel_o,
  output entry_t sel_entry_o
);

  entry_t entry_q, entry_d;
  logic   lt_q, lt_d;
  logic   sel_q, sel_d;
  logic   match;

  assign match = occ_i && (entry_q.key == ctl_i.op_key);

  always_comb begin
    lt_d  = lt_q;
    sel_d = sel_q;
    if (ctl_i.cmp_en) begin
      lt_d  = occ_i && (entry_q.key < ctl_i.op_key);
      sel_d = ctl_i.rank_mode ? rank_hit_i : match;
    end
  end

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.insert_go) begin
      // left neighbor below the new key and this one not: insertion point
      if (left_lt_i && !lt_q) begin
        entry_d.key   = ctl_i.new_entry.key;
        entry_d.seats = ctl_i.new_entry.seats;
        entry_d.line  = 8'd0;
      end else if (!left_lt_i) begin
        entry_d = left_i;
      end
    end else if (ctl_i.remove_go) begin
      // at or above the removed key: close the gap
      if (!lt_q) begin
        entry_d = right_i;
      end
    end else if (ctl_i.setline_go && sel_q) begin
      entry_d.line = ctl_i.new_entry.line;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q  <= 1'b0;
      sel_q <= 1'b0;
    end else begin
      lt_q  <= lt_d;
      sel_q <= sel_d;
    end
  end

  assign entry_o     = entry_q;
  assign lt_o        = lt_q;
  assign sel_o       = sel_q;
  assign sel_entry_o = sel_q ? entry_q : '0;

endmodule

// ----- src/skt_select.sv -----
module skt_select import skt_pkg::*; #(
  parameter int unsigned N = 64
) (
  input  logic [N-1:0] hit_i,
  input  entry_t       ent_i [N],
  output logic         any_o,
  output entry_t       ent_o
);

  // bit columns across the row, each reduced by an or tree
  logic [N-1:0] col [ENTRY_W];

  for (genvar b = 0; b < ENTRY_W; b++) begin : g_bit
    for (genvar i = 0; i < N; i++) begin : g_row
      assign col[b][i] = ent_i[i][b];
    end
    assign ent_o[b] = |col[b];
  end

  assign any_o = |hit_i;

endmodule

// ----- src/sorted_key_table.sv -----
// sorted_key_table: up to CAPACITY entries kept in ascending key order, each
// with a key, a seat count and a line. One command word per item: insert,
// lookup, set line, remove or read by rank.
// Command channel: a word is taken at a rising edge with start_i high and
// busy_o low. busy_o is high for one cycle after each accepted word.
// Result channel: done_o is high for one cycle with status and entry fields;
// the receiver cannot hold it off and must take it in that cycle.
// Order: the accepting edge registers the word. Each cell of the row
// compares its key in S_CMP; S_UPD merges the hit entry through an or
// tree, settles the status and shifts the row by one cell on insert or
// remove, and the result is registered behind done_o. The next word can
// be taken during S_UPD, while the last one is being finished.
// Configuration: cfg_we_i writes key, seat or line limit at cfg_idx_i;
// other indexes are ignored. The user must write only while no word is
// in flight; the block itself does not enforce it.
// Reset: the table is empty, limits at their maximum; there is no clearing
// pass, so a word can be taken right after reset.
module sorted_key_table import skt_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  kind_i,
  input  logic [15:0] key_i,
  input  logic [7:0]  seat_count_i,
  input  logic [7:0]  new_line_i,
  input  logic [5:0]  rank_i,
  output logic        done_o,
  output logic [3:0]  status_o,
  output logic [15:0] found_key_o,
  output logic [7:0]  found_seats_o,
  output logic [7:0]  found_line_o,
  output logic [6:0]  entry_total_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e state_q, state_d;
  logic   cmp_en, upd, accept;

  logic [CW-1:0] count_q, count_d;
  logic [15:0]   key_lim_q;
  logic [7:0]    seat_lim_q, line_lim_q;

  kind_e       op_kind_q;
  logic [15:0] op_key_q;
  logic [7:0]  op_seats_q, op_line_q;
  logic [5:0]  op_rank_q;

  ctl_t          ctl;
  entry_t        cell_ent [CAPACITY];
  entry_t        sel_ent  [CAPACITY];
  logic [CAPACITY-1:0] lt_vec, hit_vec, occ_vec, rank_vec;
  logic          any_hit;
  entry_t        hit_entry;

  logic    insert_ok, remove_ok, setline_ok;
  status_e res_status;
  entry_t  res_entry;
  logic [15:0] total_ext;

  logic    seat_bad, key_bad, line_bad, full, rank_bad;

  logic        done_q;
  status_e     status_q;
  entry_t      res_q;
  logic [6:0]  total_q;

  // control
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start_i) state_d = S_CMP;
      S_CMP:   state_d = S_UPD;
      S_UPD:   state_d = start_i ? S_CMP : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    busy_o = 1'b0;
    cmp_en = 1'b0;
    upd    = 1'b0;
    case (state_q)
      S_CMP: begin
        busy_o = 1'b1;
        cmp_en = 1'b1;
      end
      S_UPD:   upd = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_kind_q  <= kind_e'(kind_i);
      op_key_q   <= key_i;
      op_seats_q <= seat_count_i;
      op_line_q  <= new_line_i;
      op_rank_q  <= rank_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lim_q  <= 16'hFFFF;
      seat_lim_q <= 8'hFF;
      line_lim_q <= 8'hFF;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_KEY_LIMIT:  key_lim_q  <= cfg_wdata_i;
        REG_SEAT_LIMIT: seat_lim_q <= cfg_wdata_i[7:0];
        REG_LINE_LIMIT: line_lim_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // cell row
  assign ctl.cmp_en          = cmp_en;
  assign ctl.rank_mode       = (op_kind_q == KIND_RANK);
  assign ctl.insert_go       = upd && insert_ok;
  assign ctl.remove_go       = upd && remove_ok;
  assign ctl.setline_go      = upd && setline_ok;
  assign ctl.op_key          = op_key_q;
  assign ctl.new_entry.key   = op_key_q;
  assign ctl.new_entry.seats = op_seats_q;
  assign ctl.new_entry.line  = op_line_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   left_lt;

    assign occ_vec[i]  = (16'(i) < 16'(count_q));
    assign rank_vec[i] = (16'(op_rank_q) == 16'(i));

    if (i == 0) begin : g_first
      assign left_ent = cell_ent[i];
      assign left_lt  = 1'b1;
    end else begin : g_mid
      assign left_ent = cell_ent[i-1];
      assign left_lt  = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_ent = cell_ent[i];
    end else begin : g_inner
      assign right_ent = cell_ent[i+1];
    end

    skt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .occ_i       (occ_vec[i]),
      .rank_hit_i  (rank_vec[i]),
      .left_i      (left_ent),
      .left_lt_i   (left_lt),
      .right_i     (right_ent),
      .entry_o     (cell_ent[i]),
      .lt_o        (lt_vec[i]),
      .sel_o       (hit_vec[i]),
      .sel_entry_o (sel_ent[i])
    );
  end

  skt_select #(
    .N (CAPACITY)
  ) u_select (
    .hit_i (hit_vec),
    .ent_i (sel_ent),
    .any_o (any_hit),
    .ent_o (hit_entry)
  );

  // status and row commands for the update cycle
  assign seat_bad = (op_seats_q < MIN_SEATS) || (op_seats_q > seat_lim_q);
  assign key_bad  = (op_key_q == 16'd0) || (op_key_q > key_lim_q);
  assign line_bad = (op_line_q > line_lim_q);
  assign full     = (count_q == CW'(CAPACITY));
  assign rank_bad = (16'(op_rank_q) >= 16'(count_q));

  always_comb begin
    res_status = STAT_OK;
    res_entry  = '0;
    insert_ok  = 1'b0;
    remove_ok  = 1'b0;
    setline_ok = 1'b0;
    case (op_kind_q)
      KIND_INSERT: begin
        if (seat_bad)      res_status = STAT_BAD_SEATS;
        else if (key_bad)  res_status = STAT_BAD_KEY;
        else if (any_hit)  res_status = STAT_DUPLICATE;
        else if (full)     res_status = STAT_FULL;
        else begin
          insert_ok       = 1'b1;
          res_entry.key   = op_key_q;
          res_entry.seats = op_seats_q;
        end
      end
      KIND_LOOKUP: begin
        if (any_hit) res_entry  = hit_entry;
        else         res_status = STAT_NOT_FOUND;
      end
      KIND_SET_LINE: begin
        if (!any_hit) begin
          res_status = STAT_NOT_FOUND;
        end else if (line_bad) begin
          res_status = STAT_BAD_LINE;
          res_entry  = hit_entry;
        end else begin
          setline_ok     = 1'b1;
          res_entry      = hit_entry;
          res_entry.line = op_line_q;
        end
      end
      KIND_REMOVE: begin
        if (!any_hit) begin
          res_status = STAT_NOT_FOUND;
        end else if (hit_entry.line != 8'd0) begin
          res_status = STAT_HAS_LINE;
          res_entry  = hit_entry;
        end else begin
          remove_ok = 1'b1;
          res_entry = hit_entry;
        end
      end
      KIND_RANK: begin
        if (rank_bad) res_status = STAT_BAD_RANK;
        else          res_entry  = hit_entry;
      end
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (upd && insert_ok)      count_d = count_q + CW'(1);
    else if (upd && remove_ok) count_d = count_q - CW'(1);
  end

  assign total_ext = 16'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= upd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      status_q <= res_status;
      res_q    <= res_entry;
      total_q  <= total_ext[6:0];
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_key_o   = res_q.key;
  assign found_seats_o = res_q.seats;
  assign found_line_o  = res_q.line;
  assign entry_total_o = total_q;

`ifndef SYNTHESIS
  a_done_after_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_UPD))
    else $error("result strobe without an update cycle");

  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("compare cycle longer than one clock");

  a_hit_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> $onehot0(hit_vec))
    else $error("more than one cell selected");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= CAPACITY)
    else $error("entry count above capacity");
`endif

endmodule
